// ----- rtl/core/hlvg_pkg.sv -----
// Shared constants, widths and codes for the terrain vertex generator.
// Used by the core, its square root and divider pipelines and the checker.
package hlvg_pkg;

    // block geometry
    localparam int MAX_SIDE    = 64;
    localparam int MAX_LEVEL   = 4;
    localparam int STORE_DIM   = MAX_SIDE + 2;
    localparam int STORE_DEPTH = STORE_DIM * STORE_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_SIDE);
    localparam int CNT_W       = $clog2(MAX_SIDE + 1);

    // field widths
    localparam int CMD_W      = 1;
    localparam int IN_IDX_W   = 7;
    localparam int H_W        = 16;
    localparam int VPS_W      = 7;
    localparam int LVL_W      = 3;
    localparam int BS_W       = 11;
    localparam int GRID_W     = 8;
    localparam int TILE_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int POS_W      = 27;
    localparam int NRM_W      = 16;
    localparam int NY_W       = 15;
    localparam int TEX_W      = 17;

    // arithmetic widths
    localparam int DIFF_W      = H_W + 1;
    localparam int SUM_W       = 2 * DIFF_W;
    localparam int NRM_SHIFT   = 28;
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int SQRT_STAGES = RAD_W / 2;
    localparam int DIV_NW      = 52;
    localparam int DIV_DW      = 33;
    localparam int DIV_QW      = 19;
    localparam int POS_FRAC    = 8;
    localparam int TEX_FRAC    = 16;

    // value limits
    localparam int BS_MAX     = 1024;
    localparam int TILE_MAX   = 256;
    localparam int NRM_ONE    = 16384;
    localparam int TEX_ONE    = 65536;
    localparam int NRM_Y_DIFF = 512;   // the constant 2.0 of the normal, Q.8

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VPS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BSIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GCOL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES = 3'd5;

    // commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_EMIT  = 1'b1;

    // pipeline stage indexes
    localparam int ST_RAM   = 1;
    localparam int ST_DIFF  = 2;
    localparam int ST_SUM   = 3;
    localparam int ST_ROOT  = ST_SUM + SQRT_STAGES;
    localparam int ST_PREP  = ST_ROOT + 1;
    localparam int ST_QUOT  = ST_PREP + DIV_QW;
    localparam int ST_OUT   = ST_QUOT + 1;
    localparam int N_STAGES = ST_OUT + 1;

endpackage

// ----- rtl/core/heightmap_lod_vertex_generator_core.sv -----
// Terrain block vertex generator: height store, LOD decimation, normal and coordinates.
// Depends on hlvg_pkg, hlvg_ram, hlvg_sqrt and hlvg_div.
//
// The block takes one item per cycle whenever the result side keeps up. A write
// item lands in the height store at once and gives no result; an emit item passes
// the 32-stage square root of the normal length and the 19-stage dividers behind
// it before its vertex reaches the output register. Five copies of the height
// store give the five sample reads that each vertex needs in the same cycle.
// When the result is not taken the whole pipeline holds
// and no item is accepted. The store is not cleared by reset: every sample and
// border entry that an emit touches must have been written first. Configuration
// writes are always taken and must only happen while no emit is in flight.
module heightmap_lod_vertex_generator_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [hlvg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hlvg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input items
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [hlvg_pkg::CMD_W-1:0]             i_command,
    input  logic [hlvg_pkg::IN_IDX_W-1:0]          i_index_a,
    input  logic [hlvg_pkg::IN_IDX_W-1:0]          i_index_b,
    input  logic signed [hlvg_pkg::H_W-1:0]        i_height_value,
    // result items
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [hlvg_pkg::POS_W-1:0]             o_pos_x,
    output logic signed [hlvg_pkg::H_W-1:0]        o_pos_y,
    output logic [hlvg_pkg::POS_W-1:0]             o_pos_z,
    output logic signed [hlvg_pkg::NRM_W-1:0]      o_normal_x,
    output logic [hlvg_pkg::NY_W-1:0]              o_normal_y,
    output logic signed [hlvg_pkg::NRM_W-1:0]      o_normal_z,
    output logic [hlvg_pkg::TEX_W-1:0]             o_tex_u,
    output logic [hlvg_pkg::TEX_W-1:0]             o_tex_v
);

    localparam int IDX_W  = hlvg_pkg::IDX_W;
    localparam int CNT_W  = hlvg_pkg::CNT_W;
    localparam int ADDR_W = hlvg_pkg::ADDR_W;
    localparam int H_W    = hlvg_pkg::H_W;
    localparam int DIFF_W = hlvg_pkg::DIFF_W;
    localparam int SUM_W  = hlvg_pkg::SUM_W;
    localparam int NW     = hlvg_pkg::DIV_NW;
    localparam int DW     = hlvg_pkg::DIV_DW;
    localparam int QW     = hlvg_pkg::DIV_QW;
    localparam int SH_W   = CNT_W + hlvg_pkg::MAX_LEVEL - 1;
    localparam int P_W    = IDX_W + hlvg_pkg::BS_W;
    localparam int GD_W   = hlvg_pkg::GRID_W + IDX_W;
    localparam int TD_W   = hlvg_pkg::TILE_W + IDX_W;
    localparam int OFF_W  = hlvg_pkg::GRID_W + hlvg_pkg::BS_W;

    // store read ports
    localparam int RD_N   = 0;
    localparam int RD_S   = 1;
    localparam int RD_W   = 2;
    localparam int RD_E   = 3;
    localparam int RD_C   = 4;
    localparam int N_RD   = 5;

    // dividers
    localparam int DV_PX  = 0;
    localparam int DV_PZ  = 1;
    localparam int DV_TU  = 2;
    localparam int DV_TV  = 3;
    localparam int DV_NX  = 4;
    localparam int DV_NY  = 5;
    localparam int DV_NZ  = 6;
    localparam int N_DV   = 7;

    typedef struct packed {
        logic [IDX_W-1:0]         a;
        logic [IDX_W-1:0]         b;
        logic [IDX_W-1:0]         den;
        logic signed [H_W-1:0]    hc;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dz;
    } t_side;

    // configuration registers
    logic [hlvg_pkg::VPS_W-1:0]  r_vps;
    logic [hlvg_pkg::LVL_W-1:0]  r_lvl;
    logic [hlvg_pkg::BS_W-1:0]   r_bs;
    logic [hlvg_pkg::GRID_W-1:0] r_gcol;
    logic [hlvg_pkg::GRID_W-1:0] r_grow;
    logic [hlvg_pkg::TILE_W-1:0] r_tiles;

    // handshake and pipeline control
    logic                      en;
    logic                      in_acc;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [hlvg_pkg::N_STAGES-1:0] r_v;

    // stage 0 logic and registers
    logic [CNT_W-1:0]          nv;
    logic [hlvg_pkg::LVL_W-1:0] lod;
    logic [CNT_W-1:0]          vc;
    logic [CNT_W:0]            vc_inc;
    logic [CNT_W-1:0]          vc_m1;
    logic [CNT_W-1:0]          a_cl;
    logic [CNT_W-1:0]          b_cl;
    logic [SH_W-1:0]           a_sh;
    logic [SH_W-1:0]           b_sh;
    logic [IDX_W-1:0]          n0_tx;
    logic [IDX_W-1:0]          n0_tz;
    logic [IDX_W-1:0]          n0_den;
    logic [IDX_W-1:0]          r0_a;
    logic [IDX_W-1:0]          r0_b;
    logic [IDX_W-1:0]          r0_den;
    logic [IDX_W-1:0]          r0_tx;
    logic [IDX_W-1:0]          r0_tz;

    // stage 1
    logic [ADDR_W-1:0]         rd_addr [N_RD];
    logic [H_W-1:0]            rd_data [N_RD];
    logic [IDX_W-1:0]          r1_a;
    logic [IDX_W-1:0]          r1_b;
    logic [IDX_W-1:0]          r1_den;

    // stages 2 onward
    t_side                     n_side;
    t_side                     r_side [hlvg_pkg::ST_DIFF:hlvg_pkg::ST_QUOT];
    logic signed [SUM_W-1:0]   sq_x;
    logic signed [SUM_W-1:0]   sq_z;
    logic [SUM_W-1:0]          r_s;
    logic [hlvg_pkg::ROOT_W-1:0] root;

    // divider operands and results
    logic [hlvg_pkg::BS_W-1:0]   bsc;
    logic [hlvg_pkg::TILE_W-1:0] tlc;
    logic [P_W-1:0]            pa;
    logic [P_W-1:0]            pb;
    logic [GD_W-1:0]           gdc;
    logic [GD_W-1:0]           gdr;
    logic [TD_W-1:0]           td;
    logic [DIFF_W-1:0]         ax;
    logic [DIFF_W-1:0]         az;
    logic [NW-1:0]             n_dnum [N_DV];
    logic [DW-1:0]             n_dden [N_DV];
    logic [NW-1:0]             r_dnum [N_DV];
    logic [DW-1:0]             r_dden [N_DV];
    logic [QW-1:0]             quot   [N_DV];
    logic                      qsat   [N_DV];

    // output stage
    logic [OFF_W-1:0]          off_x;
    logic [OFF_W-1:0]          off_z;
    t_side                     fin;

    assign en          = !r_v[hlvg_pkg::ST_OUT] || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && en;
    assign o_out_valid = r_v[hlvg_pkg::ST_OUT];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vps   <= hlvg_pkg::VPS_W'(hlvg_pkg::MAX_SIDE);
            r_lvl   <= hlvg_pkg::LVL_W'(1);
            r_bs    <= hlvg_pkg::BS_W'(64);
            r_gcol  <= '0;
            r_grow  <= '0;
            r_tiles <= hlvg_pkg::TILE_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hlvg_pkg::CFG_VPS:   r_vps   <= i_cfg_data[hlvg_pkg::VPS_W-1:0];
                hlvg_pkg::CFG_LEVEL: r_lvl   <= i_cfg_data[hlvg_pkg::LVL_W-1:0];
                hlvg_pkg::CFG_BSIZE: r_bs    <= i_cfg_data[hlvg_pkg::BS_W-1:0];
                hlvg_pkg::CFG_GCOL:  r_gcol  <= i_cfg_data[hlvg_pkg::GRID_W-1:0];
                hlvg_pkg::CFG_GROW:  r_grow  <= i_cfg_data[hlvg_pkg::GRID_W-1:0];
                hlvg_pkg::CFG_TILES: r_tiles <= i_cfg_data[hlvg_pkg::TILE_W-1:0];
                default: ;
            endcase
        end
    end

    // store write from a write item
    assign wr_en   = in_acc && (i_command == hlvg_pkg::CMD_WRITE)
                     && (i_index_a < hlvg_pkg::STORE_DIM) && (i_index_b < hlvg_pkg::STORE_DIM);
    assign wr_addr = ADDR_W'(i_index_a) * ADDR_W'(hlvg_pkg::STORE_DIM) + ADDR_W'(i_index_b);

    // stage 0: clamps, mesh side count, saturated indices and sample position
    always_comb begin
        nv = (r_vps < hlvg_pkg::VPS_W'(2)) ? CNT_W'(2) :
             (r_vps > hlvg_pkg::VPS_W'(hlvg_pkg::MAX_SIDE)) ? CNT_W'(hlvg_pkg::MAX_SIDE) :
             CNT_W'(r_vps);
        lod = (r_lvl < hlvg_pkg::LVL_W'(1)) ? hlvg_pkg::LVL_W'(1) :
              (r_lvl > hlvg_pkg::LVL_W'(hlvg_pkg::MAX_LEVEL)) ?
              hlvg_pkg::LVL_W'(hlvg_pkg::MAX_LEVEL) : r_lvl;
        vc     = nv;
        vc_inc = '0;
        for (int k = 1; k < hlvg_pkg::MAX_LEVEL; k++) begin
            if (hlvg_pkg::LVL_W'(k) < lod) begin
                vc_inc = {1'b0, vc} + (CNT_W + 1)'(1);
                vc     = vc_inc[CNT_W:1];
            end
        end
        vc_m1  = vc - CNT_W'(1);
        a_cl   = (i_index_a > vc_m1) ? vc_m1 : CNT_W'(i_index_a);
        b_cl   = (i_index_b > vc_m1) ? vc_m1 : CNT_W'(i_index_b);
        a_sh   = SH_W'(a_cl) << (lod - hlvg_pkg::LVL_W'(1));
        b_sh   = SH_W'(b_cl) << (lod - hlvg_pkg::LVL_W'(1));
        n0_tx  = (a_cl == vc_m1) ? IDX_W'(nv - CNT_W'(1)) : a_sh[IDX_W-1:0];
        n0_tz  = (b_cl == vc_m1) ? IDX_W'(nv - CNT_W'(1)) : b_sh[IDX_W-1:0];
        n0_den = (vc > CNT_W'(1)) ? IDX_W'(vc_m1) : IDX_W'(1);
    end

    // valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[hlvg_pkg::N_STAGES-2:0],
                    in_acc && (i_command == hlvg_pkg::CMD_EMIT)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_a   <= IDX_W'(a_cl);
            r0_b   <= IDX_W'(b_cl);
            r0_den <= n0_den;
            r0_tx  <= n0_tx;
            r0_tz  <= n0_tz;
            r1_a   <= r0_a;
            r1_b   <= r0_b;
            r1_den <= r0_den;
        end
    end

    // stage 1: five neighbor reads, one store copy each
    always_comb begin
        rd_addr[RD_N] = ADDR_W'(r0_tx) * ADDR_W'(hlvg_pkg::STORE_DIM)
                        + ADDR_W'(r0_tz) + ADDR_W'(1);
        rd_addr[RD_S] = (ADDR_W'(r0_tx) + ADDR_W'(2)) * ADDR_W'(hlvg_pkg::STORE_DIM)
                        + ADDR_W'(r0_tz) + ADDR_W'(1);
        rd_addr[RD_W] = (ADDR_W'(r0_tx) + ADDR_W'(1)) * ADDR_W'(hlvg_pkg::STORE_DIM)
                        + ADDR_W'(r0_tz);
        rd_addr[RD_E] = (ADDR_W'(r0_tx) + ADDR_W'(1)) * ADDR_W'(hlvg_pkg::STORE_DIM)
                        + ADDR_W'(r0_tz) + ADDR_W'(2);
        rd_addr[RD_C] = (ADDR_W'(r0_tx) + ADDR_W'(1)) * ADDR_W'(hlvg_pkg::STORE_DIM)
                        + ADDR_W'(r0_tz) + ADDR_W'(1);
    end

    for (genvar g = 0; g < N_RD; g++) begin : g_store
        hlvg_ram #(
            .WIDTH (H_W),
            .DEPTH (hlvg_pkg::STORE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_en),
            .i_waddr (wr_addr),
            .i_wdata (i_height_value),
            .i_re    (en),
            .i_raddr (rd_addr[g]),
            .o_rdata (rd_data[g])
        );
    end

    // stage 2: central differences
    always_comb begin
        n_side.a   = r1_a;
        n_side.b   = r1_b;
        n_side.den = r1_den;
        n_side.hc  = $signed(rd_data[RD_C]);
        n_side.dx  = DIFF_W'($signed(rd_data[RD_N])) - DIFF_W'($signed(rd_data[RD_S]));
        n_side.dz  = DIFF_W'($signed(rd_data[RD_W])) - DIFF_W'($signed(rd_data[RD_E]));
    end

    // stage 3: squared length
    assign sq_x = r_side[hlvg_pkg::ST_DIFF].dx * r_side[hlvg_pkg::ST_DIFF].dx;
    assign sq_z = r_side[hlvg_pkg::ST_DIFF].dz * r_side[hlvg_pkg::ST_DIFF].dz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[hlvg_pkg::ST_DIFF] <= n_side;
            for (int k = hlvg_pkg::ST_DIFF + 1; k <= hlvg_pkg::ST_QUOT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_s <= $unsigned(sq_x) + $unsigned(sq_z)
                   + SUM_W'(hlvg_pkg::NRM_Y_DIFF * hlvg_pkg::NRM_Y_DIFF);
        end
    end

    // normal length, scaled by 2^14
    hlvg_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand (hlvg_pkg::RAD_W'(r_s) << hlvg_pkg::NRM_SHIFT),
        .o_root     (root)
    );

    // clamped registers used by the coordinate math
    assign bsc = (r_bs < hlvg_pkg::BS_W'(1)) ? hlvg_pkg::BS_W'(1) :
                 (r_bs > hlvg_pkg::BS_W'(hlvg_pkg::BS_MAX)) ? hlvg_pkg::BS_W'(hlvg_pkg::BS_MAX) :
                 r_bs;
    assign tlc = (r_tiles < hlvg_pkg::TILE_W'(1)) ? hlvg_pkg::TILE_W'(1) :
                 (r_tiles > hlvg_pkg::TILE_W'(hlvg_pkg::TILE_MAX)) ?
                 hlvg_pkg::TILE_W'(hlvg_pkg::TILE_MAX) : r_tiles;

    // divider operands: rounded quotients as (2n + d) / 2d
    always_comb begin
        t_side sd;
        sd  = r_side[hlvg_pkg::ST_ROOT];
        pa  = P_W'(sd.a) * P_W'(bsc);
        pb  = P_W'(sd.b) * P_W'(bsc);
        gdc = GD_W'(r_gcol) * GD_W'(sd.den);
        gdr = GD_W'(r_grow) * GD_W'(sd.den);
        td  = TD_W'(tlc) * TD_W'(sd.den);
        ax  = sd.dx[DIFF_W-1] ? DIFF_W'(-sd.dx) : DIFF_W'(sd.dx);
        az  = sd.dz[DIFF_W-1] ? DIFF_W'(-sd.dz) : DIFF_W'(sd.dz);

        n_dnum[DV_PX] = (NW'(pa) << (hlvg_pkg::POS_FRAC + 1)) + NW'(sd.den);
        n_dden[DV_PX] = DW'(sd.den) << 1;
        n_dnum[DV_PZ] = (NW'(pb) << (hlvg_pkg::POS_FRAC + 1)) + NW'(sd.den);
        n_dden[DV_PZ] = DW'(sd.den) << 1;
        n_dnum[DV_TU] = ((NW'(sd.a) + NW'(gdc)) << (hlvg_pkg::TEX_FRAC + 1)) + NW'(td);
        n_dden[DV_TU] = DW'(td) << 1;
        n_dnum[DV_TV] = ((NW'(sd.b) + NW'(gdr)) << (hlvg_pkg::TEX_FRAC + 1)) + NW'(td);
        n_dden[DV_TV] = DW'(td) << 1;
        n_dnum[DV_NX] = (NW'(ax) << (hlvg_pkg::NRM_SHIFT + 1)) + NW'(root);
        n_dden[DV_NX] = DW'(root) << 1;
        n_dnum[DV_NY] = (NW'(hlvg_pkg::NRM_Y_DIFF) << (hlvg_pkg::NRM_SHIFT + 1)) + NW'(root);
        n_dden[DV_NY] = DW'(root) << 1;
        n_dnum[DV_NZ] = (NW'(az) << (hlvg_pkg::NRM_SHIFT + 1)) + NW'(root);
        n_dden[DV_NZ] = DW'(root) << 1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < N_DV; k++) begin
                r_dnum[k] <= n_dnum[k];
                r_dden[k] <= n_dden[k];
            end
        end
    end

    for (genvar g = 0; g < N_DV; g++) begin : g_div
        hlvg_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_dnum[g]),
            .i_den  (r_dden[g]),
            .o_quot (quot[g]),
            .o_sat  (qsat[g])
        );
    end

    // output stage: block offsets, clamps and signs
    assign fin   = r_side[hlvg_pkg::ST_QUOT];
    assign off_x = OFF_W'(r_gcol) * OFF_W'(bsc);
    assign off_z = OFF_W'(r_grow) * OFF_W'(bsc);

    function automatic logic [hlvg_pkg::NRM_W-1:0] nrm_fix(
        input logic [hlvg_pkg::DIV_QW-1:0] q,
        input logic                        neg
    );
        logic [hlvg_pkg::NRM_W-1:0] mag;
        mag = (q > hlvg_pkg::DIV_QW'(hlvg_pkg::NRM_ONE)) ? hlvg_pkg::NRM_W'(hlvg_pkg::NRM_ONE) :
              q[hlvg_pkg::NRM_W-1:0];
        return neg ? (hlvg_pkg::NRM_W'(0) - mag) : mag;
    endfunction

    function automatic logic [hlvg_pkg::TEX_W-1:0] tex_fix(
        input logic [hlvg_pkg::DIV_QW-1:0] q,
        input logic                        sat
    );
        return (sat || (q > hlvg_pkg::DIV_QW'(hlvg_pkg::TEX_ONE))) ?
               hlvg_pkg::TEX_W'(hlvg_pkg::TEX_ONE) : q[hlvg_pkg::TEX_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pos_x    <= hlvg_pkg::POS_W'(quot[DV_PX])
                          + (hlvg_pkg::POS_W'(off_x) << hlvg_pkg::POS_FRAC);
            o_pos_z    <= hlvg_pkg::POS_W'(quot[DV_PZ])
                          + (hlvg_pkg::POS_W'(off_z) << hlvg_pkg::POS_FRAC);
            o_pos_y    <= fin.hc;
            o_normal_x <= $signed(nrm_fix(quot[DV_NX], fin.dx[DIFF_W-1]));
            o_normal_z <= $signed(nrm_fix(quot[DV_NZ], fin.dz[DIFF_W-1]));
            o_normal_y <= hlvg_pkg::NY_W'(nrm_fix(quot[DV_NY], 1'b0));
            o_tex_u    <= tex_fix(quot[DV_TU], qsat[DV_TU]);
            o_tex_v    <= tex_fix(quot[DV_TV], qsat[DV_TV]);
        end
    end

endmodule

// ----- rtl/core/hlvg_ram.sv -----
// Generic single write port RAM with one registered read port.
// No dependencies.
module hlvg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, and read old data on a same address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/hlvg_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on hlvg_pkg.
module hlvg_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [hlvg_pkg::RAD_W-1:0]    i_radicand,
    output logic [hlvg_pkg::ROOT_W-1:0]   o_root
);

    localparam int NS = hlvg_pkg::SQRT_STAGES;
    localparam int RW = hlvg_pkg::RAD_W;

    logic [RW-1:0] r_rem [NS];
    logic [RW-1:0] r_res [NS];
    logic [RW-1:0] s_rem [NS];
    logic [RW-1:0] s_res [NS];
    logic [RW-1:0] n_rem [NS];
    logic [RW-1:0] n_res [NS];

    // stage sources
    always_comb begin
        s_rem[0] = i_radicand;
        s_res[0] = '0;
        for (int j = 1; j < NS; j++) begin
            s_rem[j] = r_rem[j-1];
            s_res[j] = r_res[j-1];
        end
    end

    // one digit step per stage
    always_comb begin
        logic [RW-1:0] bitv;
        logic [RW-1:0] trial;
        bitv  = '0;
        trial = '0;
        for (int j = 0; j < NS; j++) begin
            bitv  = RW'(1) << (RW - 2 - 2 * j);
            trial = s_res[j] + bitv;
            if (s_rem[j] >= trial) begin
                n_rem[j] = s_rem[j] - trial;
                n_res[j] = (s_res[j] >> 1) + bitv;
            end else begin
                n_rem[j] = s_rem[j];
                n_res[j] = s_res[j] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NS; j++) begin
                r_rem[j] <= n_rem[j];
                r_res[j] <= n_res[j];
            end
        end
    end

    assign o_root = r_res[NS-1][hlvg_pkg::ROOT_W-1:0];

endmodule

// ----- rtl/core/hlvg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on hlvg_pkg.
module hlvg_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [hlvg_pkg::DIV_NW-1:0]   i_num,
    input  logic [hlvg_pkg::DIV_DW-1:0]   i_den,
    output logic [hlvg_pkg::DIV_QW-1:0]   o_quot,
    output logic                          o_sat
);

    localparam int NS = hlvg_pkg::DIV_QW;
    localparam int NW = hlvg_pkg::DIV_NW;
    localparam int DW = hlvg_pkg::DIV_DW;

    logic [NW-1:0] r_rem [NS];
    logic [DW-1:0] r_den [NS];
    logic [NS-1:0] r_q   [NS];
    logic          r_sat [NS];
    logic [NW-1:0] s_rem [NS];
    logic [DW-1:0] s_den [NS];
    logic [NS-1:0] s_q   [NS];
    logic          s_sat [NS];
    logic [NW-1:0] n_rem [NS];
    logic [NS-1:0] n_q   [NS];

    // stage sources; overflow when the quotient needs more than NS bits
    always_comb begin
        s_rem[0] = i_num;
        s_den[0] = i_den;
        s_q[0]   = '0;
        s_sat[0] = i_num >= (NW'(i_den) << NS);
        for (int j = 1; j < NS; j++) begin
            s_rem[j] = r_rem[j-1];
            s_den[j] = r_den[j-1];
            s_q[j]   = r_q[j-1];
            s_sat[j] = r_sat[j-1];
        end
    end

    // compare and subtract of the shifted divisor
    always_comb begin
        logic [NW-1:0] shd;
        shd = '0;
        for (int j = 0; j < NS; j++) begin
            shd = NW'(s_den[j]) << (NS - 1 - j);
            if (s_rem[j] >= shd) begin
                n_rem[j] = s_rem[j] - shd;
                n_q[j]   = s_q[j] | (NS'(1) << (NS - 1 - j));
            end else begin
                n_rem[j] = s_rem[j];
                n_q[j]   = s_q[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NS; j++) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= s_den[j];
                r_q[j]   <= n_q[j];
                r_sat[j] <= s_sat[j];
            end
        end
    end

    assign o_quot = r_q[NS-1];
    assign o_sat  = r_sat[NS-1];

endmodule

// ----- rtl/core/hlvg_checker.sv -----
// Port level checks for the terrain vertex generator, bound to the top level.
// Depends on hlvg_pkg and heightmap_lod_vertex_generator_core.
module hlvg_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_cfg_valid,
    input logic                                   o_cfg_ready,
    input logic [hlvg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input logic [hlvg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic [hlvg_pkg::CMD_W-1:0]             i_command,
    input logic [hlvg_pkg::IN_IDX_W-1:0]          i_index_a,
    input logic [hlvg_pkg::IN_IDX_W-1:0]          i_index_b,
    input logic signed [hlvg_pkg::H_W-1:0]        i_height_value,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic [hlvg_pkg::POS_W-1:0]             o_pos_x,
    input logic signed [hlvg_pkg::H_W-1:0]        o_pos_y,
    input logic [hlvg_pkg::POS_W-1:0]             o_pos_z,
    input logic signed [hlvg_pkg::NRM_W-1:0]      o_normal_x,
    input logic [hlvg_pkg::NY_W-1:0]              o_normal_y,
    input logic signed [hlvg_pkg::NRM_W-1:0]      o_normal_z,
    input logic [hlvg_pkg::TEX_W-1:0]             o_tex_u,
    input logic [hlvg_pkg::TEX_W-1:0]             o_tex_v
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a held result stays valid; its positions, x and z normals and u coordinate stay put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_x) && $stable(o_pos_z)
            && $stable(o_normal_x) && $stable(o_normal_z) && $stable(o_tex_u))
        else $error("held result changed");

    // a stalled result side stops input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item taken while result stalled");

    // normal components stay within unit range
    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_normal_y <= hlvg_pkg::NY_W'(hlvg_pkg::NRM_ONE))
            && (o_normal_x <= hlvg_pkg::NRM_ONE) && (o_normal_x >= -hlvg_pkg::NRM_ONE)
            && (o_normal_z <= hlvg_pkg::NRM_ONE) && (o_normal_z >= -hlvg_pkg::NRM_ONE))
        else $error("normal out of range");

    // texture coordinates saturate at one
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tex_u <= hlvg_pkg::TEX_W'(hlvg_pkg::TEX_ONE))
            && (o_tex_v <= hlvg_pkg::TEX_W'(hlvg_pkg::TEX_ONE)))
        else $error("texture coordinate above one");

endmodule

bind heightmap_lod_vertex_generator_core hlvg_checker u_hlvg_checker (.*);

// ----- verif/tb_heightmap_lod_vertex_generator_core.sv -----
// Testbench for heightmap_lod_vertex_generator_core: directed and random items
// checked against a cycle-free vertex predictor. Depends on hlvg_pkg and the core RTL.
module tb_heightmap_lod_vertex_generator_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 4000;

    typedef struct {
        logic [hlvg_pkg::POS_W-1:0]        px;
        logic signed [hlvg_pkg::H_W-1:0]   py;
        logic [hlvg_pkg::POS_W-1:0]        pz;
        logic signed [hlvg_pkg::NRM_W-1:0] nx;
        logic [hlvg_pkg::NY_W-1:0]         ny;
        logic signed [hlvg_pkg::NRM_W-1:0] nz;
        logic [hlvg_pkg::TEX_W-1:0]        tu;
        logic [hlvg_pkg::TEX_W-1:0]        tv;
    } t_vertex;

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready;
    logic [hlvg_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [hlvg_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid, o_in_ready;
    logic [hlvg_pkg::CMD_W-1:0] i_command;
    logic [hlvg_pkg::IN_IDX_W-1:0] i_index_a, i_index_b;
    logic signed [hlvg_pkg::H_W-1:0] i_height_value;
    logic o_out_valid, i_out_ready;
    logic [hlvg_pkg::POS_W-1:0] o_pos_x, o_pos_z;
    logic signed [hlvg_pkg::H_W-1:0] o_pos_y;
    logic signed [hlvg_pkg::NRM_W-1:0] o_normal_x, o_normal_z;
    logic [hlvg_pkg::NY_W-1:0] o_normal_y;
    logic [hlvg_pkg::TEX_W-1:0] o_tex_u, o_tex_v;

    heightmap_lod_vertex_generator_core uut (.*);

    // predictor state: height store, which entries hold data, registers
    logic signed [hlvg_pkg::H_W-1:0] height_mirror [0:hlvg_pkg::STORE_DIM-1]
                                                   [0:hlvg_pkg::STORE_DIM-1];
    bit entry_loaded [0:hlvg_pkg::STORE_DIM-1][0:hlvg_pkg::STORE_DIM-1];
    int unsigned reg_vps = 64, reg_level = 1, reg_bsize = 64;
    int unsigned reg_gcol = 0, reg_grow = 0, reg_tiles = 1;

    t_vertex pending_vertices[$];
    int      error_count = 0;
    int      items_sent  = 0;
    int      idle_cycles = 0;
    bit      sender_calm = 0;
    bit      receiver_calm = 0;
    int      burst_left = 0;
    int      stall_left = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // mesh side count at the current detail level
    function automatic int unsigned mesh_side();
        int unsigned vc;
        vc = clamp_u(reg_vps, 2, hlvg_pkg::MAX_SIDE);
        for (int k = 1; k < clamp_u(reg_level, 1, hlvg_pkg::MAX_LEVEL); k++) vc = (vc + 1) >> 1;
        return vc;
    endfunction

    // sample position of vertex (a,b) after saturation and decimation
    function automatic void vertex_site(int unsigned a, int unsigned b,
                                        output int unsigned tx, output int unsigned tz);
        int unsigned vc, nv, stride;
        vc = mesh_side();
        nv = clamp_u(reg_vps, 2, hlvg_pkg::MAX_SIDE);
        stride = 1 << (clamp_u(reg_level, 1, hlvg_pkg::MAX_LEVEL) - 1);
        if (a > vc - 1) a = vc - 1;
        if (b > vc - 1) b = vc - 1;
        tx = (a == vc - 1) ? nv - 1 : a * stride;
        tz = (b == vc - 1) ? nv - 1 : b * stride;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, probe;
        root = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // one normal component, rounded and capped at one
    function automatic longint unit_component(longint c, longint unsigned len);
        longint unsigned mag, q;
        mag = c < 0 ? -c : c;
        q = (2 * (mag << hlvg_pkg::NRM_SHIFT) + len) / (2 * len);
        if (q > hlvg_pkg::NRM_ONE) q = hlvg_pkg::NRM_ONE;
        return c < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned world_coord(int unsigned i, int unsigned den,
                                                    int unsigned grid, int unsigned bs);
        longint unsigned num;
        num = longint'(i) * bs * 256;
        return (2 * num + den) / (2 * longint'(den)) + longint'(grid) * bs * 256;
    endfunction

    function automatic longint unsigned tex_coord(int unsigned i, int unsigned den,
                                                  int unsigned grid, int unsigned tiles);
        longint unsigned num, d, t;
        num = (longint'(i) + longint'(grid) * den) * 65536;
        d = longint'(tiles) * den;
        t = (2 * num + d) / (2 * d);
        return t > hlvg_pkg::TEX_ONE ? hlvg_pkg::TEX_ONE : t;
    endfunction

    function automatic t_vertex predict_vertex(int unsigned a, int unsigned b);
        t_vertex v;
        int unsigned vc, den, tx, tz, bs, tiles;
        longint dx, dz;
        longint unsigned len;
        vc = mesh_side();
        bs = clamp_u(reg_bsize, 1, hlvg_pkg::BS_MAX);
        tiles = clamp_u(reg_tiles, 1, hlvg_pkg::TILE_MAX);
        vertex_site(a, b, tx, tz);
        if (a > vc - 1) a = vc - 1;
        if (b > vc - 1) b = vc - 1;
        den = vc > 1 ? vc - 1 : 1;
        dx = longint'(height_mirror[tx][tz+1]) - longint'(height_mirror[tx+2][tz+1]);
        dz = longint'(height_mirror[tx+1][tz]) - longint'(height_mirror[tx+1][tz+2]);
        len = int_sqrt(longint'(dx * dx + hlvg_pkg::NRM_Y_DIFF * hlvg_pkg::NRM_Y_DIFF + dz * dz)
                       << hlvg_pkg::NRM_SHIFT);
        v.px = hlvg_pkg::POS_W'(world_coord(a, den, reg_gcol, bs));
        v.py = height_mirror[tx+1][tz+1];
        v.pz = hlvg_pkg::POS_W'(world_coord(b, den, reg_grow, bs));
        v.nx = hlvg_pkg::NRM_W'(unit_component(dx, len));
        v.ny = hlvg_pkg::NY_W'(unit_component(hlvg_pkg::NRM_Y_DIFF, len));
        v.nz = hlvg_pkg::NRM_W'(unit_component(dz, len));
        v.tu = hlvg_pkg::TEX_W'(tex_coord(a, den, reg_gcol, tiles));
        v.tv = hlvg_pkg::TEX_W'(tex_coord(b, den, reg_grow, tiles));
        return v;
    endfunction

    // send one item with burst gaps; predict on acceptance
    task automatic send_item(logic [hlvg_pkg::CMD_W-1:0] cmd, int unsigned a, int unsigned b,
                             logic signed [hlvg_pkg::H_W-1:0] h);
        int gap;
        if (!sender_calm && burst_left == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_index_a      <= hlvg_pkg::IN_IDX_W'(a);
        i_index_b      <= hlvg_pkg::IN_IDX_W'(b);
        i_height_value <= h;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (cmd == hlvg_pkg::CMD_EMIT) begin
            pending_vertices.insert(pending_vertices.size(), predict_vertex(a, b));
        end else if (a < hlvg_pkg::STORE_DIM && b < hlvg_pkg::STORE_DIM) begin
            height_mirror[a][b] = h;
            entry_loaded[a][b] = 1'b1;
        end
    endtask

    task automatic write_cell(int unsigned r, int unsigned c,
                              logic signed [hlvg_pkg::H_W-1:0] h);
        send_item(hlvg_pkg::CMD_WRITE, r, c, h);
    endtask

    // load any of the five samples still empty, then emit the vertex
    task automatic emit_vertex(int unsigned a, int unsigned b);
        int unsigned tx, tz;
        vertex_site(a, b, tx, tz);
        if (!entry_loaded[tx][tz+1])   write_cell(tx, tz + 1, hlvg_pkg::H_W'($urandom));
        if (!entry_loaded[tx+2][tz+1]) write_cell(tx + 2, tz + 1, hlvg_pkg::H_W'($urandom));
        if (!entry_loaded[tx+1][tz])   write_cell(tx + 1, tz, hlvg_pkg::H_W'($urandom));
        if (!entry_loaded[tx+1][tz+2]) write_cell(tx + 1, tz + 2, hlvg_pkg::H_W'($urandom));
        if (!entry_loaded[tx+1][tz+1]) write_cell(tx + 1, tz + 1, hlvg_pkg::H_W'($urandom));
        send_item(hlvg_pkg::CMD_EMIT, a, b, hlvg_pkg::H_W'($urandom));
    endtask

    // lower valid and wait until every vertex has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
    endtask

    // register write, only with the pipeline empty
    task automatic program_reg(logic [hlvg_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
        drain();
        repeat (64) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= hlvg_pkg::CFG_DATA_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            hlvg_pkg::CFG_VPS:   reg_vps   = data & 7'h7F;
            hlvg_pkg::CFG_LEVEL: reg_level = data & 3'h7;
            hlvg_pkg::CFG_BSIZE: reg_bsize = data & 11'h7FF;
            hlvg_pkg::CFG_GCOL:  reg_gcol  = data & 8'hFF;
            hlvg_pkg::CFG_GROW:  reg_grow  = data & 8'hFF;
            hlvg_pkg::CFG_TILES: reg_tiles = data & 9'h1FF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // steep and flat normals, far corner, saturated indices, ignored writes
    task automatic test_default_geometry();
        write_cell(5, 6, 16'sh7FFF);
        write_cell(7, 6, -16'sh8000);
        write_cell(6, 5, -16'sh8000);
        write_cell(6, 7, 16'sh7FFF);
        write_cell(6, 6, -16'sh8000);
        emit_vertex(5, 5);
        for (int r = 10; r <= 12; r++)
            for (int c = 10; c <= 12; c++) write_cell(r, c, '0);
        emit_vertex(10, 10);
        write_cell(127, 3, 16'sh1234);
        write_cell(4, 127, 16'sh1234);
        write_cell(66, 66, 16'sh5555);
        emit_vertex(0, 0);
        emit_vertex(63, 63);
        emit_vertex(127, 127);
        emit_vertex(0, 100);
    endtask

    // register extremes: single vertex mesh, texture overflow, largest world
    task automatic test_register_extremes();
        program_reg(hlvg_pkg::CFG_VPS, 2);
        program_reg(hlvg_pkg::CFG_LEVEL, 4);
        emit_vertex(0, 0);
        emit_vertex(5, 9);
        program_reg(hlvg_pkg::CFG_VPS, 64);
        program_reg(hlvg_pkg::CFG_LEVEL, 1);
        program_reg(hlvg_pkg::CFG_BSIZE, 1024);
        program_reg(hlvg_pkg::CFG_GCOL, 255);
        program_reg(hlvg_pkg::CFG_GROW, 255);
        program_reg(hlvg_pkg::CFG_TILES, 1);
        emit_vertex(63, 63);
        emit_vertex(1, 62);
        program_reg(hlvg_pkg::CFG_TILES, 256);
        program_reg(hlvg_pkg::CFG_BSIZE, 1);
        program_reg(hlvg_pkg::CFG_GCOL, 0);
        emit_vertex(0, 63);
        program_reg(hlvg_pkg::CFG_LEVEL, 7);
        program_reg(hlvg_pkg::CFG_VPS, 127);
        program_reg(hlvg_pkg::CFG_BSIZE, 2047);
        program_reg(hlvg_pkg::CFG_TILES, 511);
        emit_vertex(7, 3);
        program_reg(hlvg_pkg::CFG_VPS, 0);
        program_reg(hlvg_pkg::CFG_LEVEL, 0);
        program_reg(hlvg_pkg::CFG_BSIZE, 0);
        program_reg(hlvg_pkg::CFG_TILES, 0);
        emit_vertex(1, 0);
    endtask

    // random settings, each followed by a run of mostly valid emits
    task automatic test_random_meshes();
        int phase, len, vc;
        phase = 0;
        while (items_sent < 1450) begin
            case ($urandom_range(0, 9))
                0:       program_reg(hlvg_pkg::CFG_VPS, $urandom_range(0, 127));
                1:       program_reg(hlvg_pkg::CFG_VPS, 64);
                default: program_reg(hlvg_pkg::CFG_VPS, $urandom_range(2, 12));
            endcase
            program_reg(hlvg_pkg::CFG_LEVEL, $urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                                       : $urandom_range(1, 4));
            program_reg(hlvg_pkg::CFG_BSIZE, $urandom_range(0, 2047));
            program_reg(hlvg_pkg::CFG_GCOL, $urandom_range(0, 255));
            program_reg(hlvg_pkg::CFG_GROW, $urandom_range(0, 255));
            program_reg(hlvg_pkg::CFG_TILES, $urandom_range(0, 4) == 0 ? $urandom_range(0, 511)
                                                                       : $urandom_range(1, 16));
            sender_calm   = (phase % 3) == 1;
            receiver_calm = (phase % 4) == 2;
            vc = mesh_side();
            len = $urandom_range(40, 120);
            for (int n = 0; n < len; n++) begin
                if (n == len / 2 && phase % 5 == 0) drain();
                case ($urandom_range(0, 9))
                    0:    write_cell($urandom_range(0, 127), $urandom_range(0, 127),
                                     hlvg_pkg::H_W'($urandom));
                    1:    write_cell($urandom_range(0, hlvg_pkg::STORE_DIM - 1),
                                     $urandom_range(0, hlvg_pkg::STORE_DIM - 1),
                                     hlvg_pkg::H_W'($urandom));
                    2:    emit_vertex($urandom_range(0, 127), $urandom_range(0, 127));
                    default: emit_vertex($urandom_range(0, vc - 1), $urandom_range(0, vc - 1));
                endcase
            end
            phase++;
        end
        sender_calm = 0;
        receiver_calm = 0;
    endtask

    // result side: stalls on its own pattern, quiet in calm phases
    always @(negedge i_clk) begin
        if (!i_rst_n || receiver_calm) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
        end
    end

    task automatic check_field(string name, longint exp, longint act);
        if (exp != act) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            error_count++;
        end
    endtask

    // compare each vertex with the oldest prediction
    always @(posedge i_clk) begin
        t_vertex v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_vertices.size() == 0) begin
                $error("vertex out with none pending");
                error_count++;
            end else begin
                v = pending_vertices.pop_front();
                check_field("pos_x", v.px, o_pos_x);
                check_field("pos_y", v.py, o_pos_y);
                check_field("pos_z", v.pz, o_pos_z);
                check_field("normal_x", v.nx, o_normal_x);
                check_field("normal_y", v.ny, o_normal_y);
                check_field("normal_z", v.nz, o_normal_z);
                check_field("tex_u", v.tu, o_tex_u);
                check_field("tex_v", v.tv, o_tex_v);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = hlvg_pkg::CMD_WRITE;
        i_index_a = '0;
        i_index_b = '0;
        i_height_value = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_geometry();
        test_register_extremes();
        test_random_meshes();
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_vertices.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
